### hw/rtl/sorted_priority_queue_assert.svh
// Assertion macros for the priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SPQ_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("priority queue assertion failed");

`define SPQ_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("priority queue assertion failed");

`else

`define SPQ_ASSERT_SAME(label, clk, rst, pre, post)

`define SPQ_ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

### hw/rtl/spq_pkg.sv
// Constants, codes and types of the sorted priority queue.
package spq_pkg;

   localparam int DEPTH        = 8;
   localparam int PRI_WIDTH    = 8;
   localparam int DATA_WIDTH   = 32;
   localparam int CNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int STATUS_WIDTH = 2;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_DEQUEUE = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic [PRI_WIDTH-1:0]  prio;
   } entry_type;

   // Per-cell control: enq/deq are already qualified by full/empty.
   typedef struct packed {
      logic enq;
      logic deq;
      logic occupied;
      logic tail;
   } cell_ctrl_type;

endpackage

### hw/rtl/spq_if.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if import spq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         cmd;
   logic signed [DATA_WIDTH-1:0] item_value;
   logic [PRI_WIDTH-1:0]         item_priority;

   modport source (output valid, output cmd, output item_value, output item_priority,
                   input ready);
   modport sink (input valid, input cmd, input item_value, input item_priority,
                 output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [STATUS_WIDTH-1:0]      status;
   logic signed [DATA_WIDTH-1:0] out_value;
   logic [PRI_WIDTH-1:0]         out_priority;
   logic [CNT_WIDTH-1:0]         occupancy;

   modport source (output valid, output status, output out_value, output out_priority,
                   output occupancy, input ready);
   modport sink (input valid, input status, input out_value, input out_priority,
                 input occupancy, output ready);
endinterface

### hw/rtl/sorted_priority_queue.sv
// Sorted priority queue: request and response channels over a chain of cells.
//
// Requests arrive on req_ch (valid/ready). cmd selects enqueue of
// item_value with item_priority, or dequeue of the highest-priority entry.
// Entries of equal priority leave in the order they arrived.
// Every request produces exactly one response on rsp_ch: status (ok,
// overflow on a full enqueue, underflow on an empty dequeue), the removed
// value and priority on a successful dequeue (zero otherwise) and the
// occupancy after the operation.
// The response sits in an output register and is shown in the cycle after
// its request is taken. One request is taken every cycle unless a response
// stalls: each cell compares its own priority with the incoming one and all
// cells shift in the same cycle, so depth does not affect timing. While the
// receiver stalls a held response, req_ch.ready is low, the queue unchanged.
// Reset empties the queue and drops any pending response; the block is
// ready in the first cycle after reset.
module sorted_priority_queue import spq_pkg::*; (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_ch,
   spq_rsp_if.source rsp_ch
);

`include "sorted_priority_queue_assert.svh"

   logic [CNT_WIDTH-1:0]    count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   entry_type               head_ff, head_in;
   logic [CNT_WIDTH-1:0]    occ_ff;

   logic      req_fire;
   logic      is_full;
   logic      is_empty;
   logic      do_enq;
   logic      do_deq;
   entry_type new_entry;

   entry_type cell_entry [DEPTH];
   logic      cell_move  [DEPTH];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign is_full      = (count_ff == CNT_WIDTH'(DEPTH));
   assign is_empty     = (count_ff == '0);
   assign do_enq       = req_fire && (req_ch.cmd == CMD_ENQUEUE) && !is_full;
   assign do_deq       = req_fire && (req_ch.cmd == CMD_DEQUEUE) && !is_empty;

   assign new_entry.value = req_ch.item_value;
   assign new_entry.prio  = req_ch.item_priority;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     left_entry;
      entry_type     right_entry;
      logic          left_move;

      assign ctrl.enq      = do_enq;
      assign ctrl.deq      = do_deq;
      assign ctrl.occupied = (CNT_WIDTH'(i) < count_ff);
      assign ctrl.tail     = (CNT_WIDTH'(i) == count_ff);

      if (i == 0) begin : g_head
         assign left_move  = 1'b0;
         assign left_entry = new_entry;
      end else begin : g_body
         assign left_move  = cell_move[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .new_entry   (new_entry),
         .left_move   (left_move),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .entry       (cell_entry[i]),
         .move        (cell_move[i])
      );
   end

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_OK;
      head_in   = '0;
      if (do_enq) begin
         count_in = count_ff + CNT_WIDTH'(1);
      end else if (do_deq) begin
         count_in = count_ff - CNT_WIDTH'(1);
         head_in  = cell_entry[0];
      end else if (req_ch.cmd == CMD_ENQUEUE) begin
         status_in = STATUS_OVERFLOW;
      end else begin
         status_in = STATUS_UNDERFLOW;
      end
   end

   always_comb begin
      if (req_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         status_ff <= status_in;
         head_ff   <= head_in;
         occ_ff    <= count_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.out_value    = head_ff.value;
   assign rsp_ch.out_priority = head_ff.prio;
   assign rsp_ch.occupancy    = occ_ff;

   // The fill count never goes past the number of cells.
   `SPQ_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_WIDTH'(DEPTH))

   // A successful enqueue grows the queue by exactly one entry.
   `SPQ_ASSERT_NEXT(a_enq_grows, clock, reset, do_enq,
                    count_ff == $past(count_ff) + CNT_WIDTH'(1))

   // The head never holds a lower priority than the entry behind it.
   `SPQ_ASSERT_SAME(a_head_sorted, clock, reset, count_ff >= CNT_WIDTH'(2),
                    cell_entry[0].prio >= cell_entry[1].prio)

   // A rejected request leaves the queue size unchanged.
   `SPQ_ASSERT_NEXT(a_reject_holds, clock, reset, req_fire && !do_enq && !do_deq,
                    count_ff == $past(count_ff))

endmodule

### hw/rtl/spq_cell.sv
// One slot of the sorted chain: holds an entry and shifts with its neighbours.
module spq_cell import spq_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     new_entry,
   input  logic          left_move,
   input  entry_type     left_entry,
   input  entry_type     right_entry,
   output entry_type     entry,
   output logic          move
);

   entry_type entry_ff;
   entry_type entry_in;

   // On enqueue the cells holding a lower priority, plus the first free
   // slot, form a contiguous run that moves one place towards the tail.
   assign move = ctrl.enq && (ctrl.tail || (ctrl.occupied && (new_entry.prio > entry_ff.prio)));

   always_comb begin
      entry_in = entry_ff;
      if (move) begin
         entry_in = left_move ? left_entry : new_entry;
      end else if (ctrl.deq) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
